// ===== src/vdd_pkg.sv =====
// ----------------------------------------------------------------------------
// Vertex dedup package
// Shared constants and the float32 equality helper.
// ----------------------------------------------------------------------------
package vdd_pkg;

  localparam int unsigned TableDepthDef   = 256;
  localparam int unsigned SourceBitsDef   = 16;
  localparam int unsigned VertexCountBits = 16;
  localparam int unsigned IndexOutBits    = 8;
  localparam int unsigned CfgIndexBits    = 1;

  localparam logic [CfgIndexBits-1:0] CfgMatchBySource = 1'b0;
  localparam logic [CfgIndexBits-1:0] CfgVertexCount   = 1'b1;

  localparam logic CmdLookup = 1'b0;
  localparam logic CmdClear  = 1'b1;

  localparam logic [31:0] FloatOne = 32'h3F80_0000;

  // IEEE equality: +0 equals -0, NaN equals nothing.
  function automatic logic f32_eq(input logic [31:0] a, input logic [31:0] b);
    logic a_nan;
    logic b_nan;
    a_nan = (a[30:23] == 8'hFF) && (a[22:0] != 23'd0);
    b_nan = (b[30:23] == 8'hFF) && (b[22:0] != 23'd0);
    if (a_nan || b_nan) begin
      return 1'b0;
    end
    if ((a[30:0] == 31'd0) && (b[30:0] == 31'd0)) begin
      return 1'b1;
    end
    return a == b;
  endfunction

endpackage

// ===== src/vdd_ram.sv =====
// ----------------------------------------------------------------------------
// Generic RAM
// Single write port, single read port with a registered read.
// ----------------------------------------------------------------------------
module vdd_ram #(
  parameter int unsigned Width = 32,
  parameter int unsigned Depth = 256
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_o <= mem[raddr_i];
  end

endmodule

// ===== src/vdd_flip.sv =====
// ----------------------------------------------------------------------------
// Float flip unit
// Computes 1.0 - v in float32, round to nearest even, as a sequence of steps:
// one alignment shift per cycle, then add/subtract, then a one-bit-per
// cycle normalization, then rounding.
// ----------------------------------------------------------------------------
module vdd_flip (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  input  logic [31:0] v_i,
  output logic        done_o,
  output logic [31:0] res_o
);

  import vdd_pkg::*;

  typedef enum logic [2:0] {
    FIdle, FAlign, FAdd, FNorm, FRound
  } fstate_e;

  // Operation is a - b with a = 1.0, b = v.  As a + (-v).
  fstate_e     state_q, state_d;
  logic        sa_q, sa_d;          // sign of larger-magnitude operand
  logic        sb_q, sb_d;
  logic [7:0]  ea_q, ea_d;          // exponent of larger operand
  logic [26:0] ma_q, ma_d;          // mantissa with guard/round/sticky
  logic [26:0] mb_q, mb_d;
  logic [8:0]  shamt_q, shamt_d;
  logic [27:0] sum_q, sum_d;
  logic [9:0]  exp_q, exp_d;        // signed-ish working exponent
  logic [31:0] res_q, res_d;
  logic        done_q, done_d;

  logic        v_nan, v_inf, v_zero;
  logic [7:0]  ve_eff;
  logic [23:0] vm;
  logic        nb;
  logic [27:0] rnd;
  logic        lsb, grd, rbit, stk, inc;

  always_comb begin
    ve_eff = (v_i[30:23] == 8'd0) ? 8'd1 : v_i[30:23];
    vm     = {(v_i[30:23] != 8'd0), v_i[22:0]};
    v_nan  = (v_i[30:23] == 8'hFF) && (v_i[22:0] != 23'd0);
    v_inf  = (v_i[30:23] == 8'hFF) && (v_i[22:0] == 23'd0);
    v_zero = (v_i[30:0] == 31'd0);
    nb     = ~v_i[31];
    state_d = state_q;
    sa_d = sa_q; sb_d = sb_q; ea_d = ea_q;
    ma_d = ma_q; mb_d = mb_q; shamt_d = shamt_q; sum_d = sum_q;
    exp_d = exp_q; res_d = res_q; done_d = 1'b0;
    rnd = 28'd0; lsb = 1'b0; grd = 1'b0; rbit = 1'b0; stk = 1'b0; inc = 1'b0;
    unique case (state_q)
      FIdle: begin
        if (start_i) begin
          if (v_nan) begin
            res_d = {v_i[31], 8'hFF, 1'b1, v_i[21:0]};
            done_d = 1'b1;
          end else if (v_inf) begin
            res_d = {nb, 8'hFF, 23'd0};
            done_d = 1'b1;
          end else if (v_zero) begin
            res_d = FloatOne;
            done_d = 1'b1;
          end else if ({ve_eff, vm} > {8'd127, 24'h80_0000}) begin
            // |v| larger: it leads
            sa_d = nb; ea_d = ve_eff; ma_d = {vm, 3'd0};
            sb_d = 1'b0; mb_d = {24'h80_0000, 3'd0};
            shamt_d = {1'b0, ve_eff - 8'd127};
            state_d = FAlign;
          end else begin
            sa_d = 1'b0; ea_d = 8'd127; ma_d = {24'h80_0000, 3'd0};
            sb_d = nb; mb_d = {vm, 3'd0};
            shamt_d = {1'b0, 8'd127 - ve_eff};
            state_d = FAlign;
          end
        end
      end
      FAlign: begin
        // Shift the smaller operand right one place per cycle, keep sticky.
        if (shamt_q == 9'd0 || mb_q == 27'd0) begin
          state_d = FAdd;
        end else begin
          mb_d = {1'b0, mb_q[26:2], mb_q[1] | mb_q[0]};
          shamt_d = shamt_q - 9'd1;
        end
      end
      FAdd: begin
        if (sa_q == sb_q) begin
          sum_d = {1'b0, ma_q} + {1'b0, mb_q};
        end else begin
          sum_d = {1'b0, ma_q} - {1'b0, mb_q};
        end
        exp_d = {2'b00, ea_q};
        if (sum_d == 28'd0) begin
          res_d = 32'd0;
          done_d = 1'b1;
          state_d = FIdle;
        end else begin
          state_d = FNorm;
        end
      end
      FNorm: begin
        if (sum_q[27]) begin
          sum_d = {1'b0, sum_q[27:2], sum_q[1] | sum_q[0]};
          exp_d = exp_q + 10'd1;
          state_d = FRound;
        end else if (!sum_q[26] && exp_q > 10'd1) begin
          sum_d = {sum_q[26:0], 1'b0};
          exp_d = exp_q - 10'd1;
        end else begin
          state_d = FRound;
        end
      end
      FRound: begin
        lsb  = sum_q[3];
        grd  = sum_q[2];
        rbit = sum_q[1];
        stk  = sum_q[0];
        inc  = grd & (rbit | stk | lsb);
        rnd  = {1'b0, sum_q[27:3]} + {27'd0, inc};
        // rnd[24] set means a carry into a new binade
        if (rnd[24]) begin
          res_d = {sa_q, exp_q[7:0] + 8'd1, rnd[23:1]};
          if (exp_q[7:0] + 8'd1 == 8'hFF) begin
            res_d = {sa_q, 8'hFF, 23'd0};
          end
        end else if (!rnd[23]) begin
          res_d = {sa_q, 8'd0, rnd[22:0]};
        end else begin
          res_d = {sa_q, exp_q[7:0], rnd[22:0]};
        end
        done_d = 1'b1;
        state_d = FIdle;
      end
      default: state_d = FIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= FIdle;
      done_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      done_q  <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    sa_q <= sa_d; sb_q <= sb_d; ea_q <= ea_d;
    ma_q <= ma_d; mb_q <= mb_d; shamt_q <= shamt_d; sum_q <= sum_d;
    exp_q <= exp_d; res_q <= res_d;
  end

  assign done_o = done_q;
  assign res_o  = res_q;

endmodule

// ===== src/vertex_dedup_get_or_append.sv =====
// ----------------------------------------------------------------------------
// Vertex dedup get-or-append table
// Looks up a textured vertex in a table and appends it when it is new.
// ----------------------------------------------------------------------------
// Usage: a command transaction arrives on the s_axis group. tuser carries the
// command (0 lookup or append, 1 clear). tdata carries, from the lowest bit
// up: source_index, pos_x, pos_y, pos_z, tex_u, tex_v. Every transaction
// yields exactly one result transaction on m_axis, whose tdata holds from
// the lowest bit up: entry_index, appended, table_full, range_error.
// A lookup first computes v' = 1.0 - v in a small multicycle float unit, which
// aligns by one place per cycle (the exponent distance between v and 1.0,
// at most 127) and normalizes one bit per cycle. It then scans the filled
// entries through the entry memory one at a time, presenting the address in
// SScan and comparing the read data in SCheck because the read port is
// registered. A clear answers in the cycle after acceptance.
// The block takes one transaction at a time: s_axis_tready is high only when
// no transaction is in work and the result register is empty.
// If the receiver stalls, the result waits in the output register and the
// block accepts no new transaction. Reset empties the table (fill count
// zero) and sets both configuration registers to zero; the entry memories
// need no clearing because only entries below the fill count are read.
// Configuration is written through cfg_we_i, cfg_index_i and cfg_data_i.
// ----------------------------------------------------------------------------
module vertex_dedup_get_or_append #(
  parameter int unsigned TableDepth = vdd_pkg::TableDepthDef,
  parameter int unsigned SourceBits = vdd_pkg::SourceBitsDef
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               cfg_we_i,
  input  logic [vdd_pkg::CfgIndexBits-1:0]   cfg_index_i,
  input  logic [vdd_pkg::VertexCountBits-1:0] cfg_data_i,
  input  logic                               s_axis_tvalid,
  output logic                               s_axis_tready,
  // source_index, pos_x, pos_y, pos_z, tex_u, tex_v (zero padded)
  input  logic [((SourceBits+160+7)/8)*8-1:0] s_axis_tdata,
  // command
  input  logic                               s_axis_tuser,
  output logic                               m_axis_tvalid,
  input  logic                               m_axis_tready,
  // entry_index, appended, table_full, range_error
  output logic [15:0]                        m_axis_tdata
);

  import vdd_pkg::*;

  localparam int unsigned AddrBits  = $clog2(TableDepth);
  localparam int unsigned CountBits = $clog2(TableDepth + 1);
  localparam int unsigned EntryBits = SourceBits + 160;

  typedef enum logic [2:0] {
    SIdle, SFlip, SScan, SWait, SCheck, SDone
  } state_e;

  // Field order follows tdata: the source index sits in the lowest bits.
  typedef struct packed {
    logic [31:0]           v;
    logic [31:0]           u;
    logic [31:0]           z;
    logic [31:0]           y;
    logic [31:0]           x;
    logic [SourceBits-1:0] src;
  } entry_t;

  state_e                state_q, state_d;
  logic                  by_src_q;
  logic [15:0]           vcount_q;
  logic [CountBits-1:0]  fill_q, fill_d;
  logic [CountBits-1:0]  scan_q, scan_d;
  entry_t                item_q, item_d;
  logic                  rerr_q, rerr_d;
  logic                  ovalid_q, ovalid_d;
  logic [15:0]           odata_q, odata_d;
  logic                  flip_start, flip_done;
  logic [31:0]           flip_res;
  logic                  we;
  logic [AddrBits-1:0]   raddr;
  logic [EntryBits-1:0]  rdata;
  entry_t                rd;
  logic                  hit;
  logic                  in_acc;
  logic [IndexOutBits-1:0] scan_idx, fill_idx;

  assign in_acc = s_axis_tvalid && s_axis_tready;
  assign s_axis_tready = (state_q == SIdle) && !ovalid_q;

  vdd_flip u_flip (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start_i(flip_start),
    .v_i    (item_q.v),
    .done_o (flip_done),
    .res_o  (flip_res)
  );

  vdd_ram #(.Width(EntryBits), .Depth(TableDepth)) u_ram (
    .clk_i  (clk_i),
    .we_i   (we),
    .waddr_i(fill_q[AddrBits-1:0]),
    .wdata_i(item_q),
    .raddr_i(raddr),
    .rdata_o(rdata)
  );

  assign rd = entry_t'(rdata);
  assign raddr = scan_q[AddrBits-1:0];
  assign scan_idx = IndexOutBits'(scan_q);
  assign fill_idx = IndexOutBits'(fill_q);

  always_comb begin
    if (by_src_q) begin
      hit = (rd.src == item_q.src) && f32_eq(rd.u, item_q.u) && f32_eq(rd.v, item_q.v);
    end else begin
      hit = f32_eq(rd.x, item_q.x) && f32_eq(rd.y, item_q.y) && f32_eq(rd.z, item_q.z)
            && f32_eq(rd.u, item_q.u) && f32_eq(rd.v, item_q.v);
    end
  end

  always_comb begin
    state_d = state_q; fill_d = fill_q; scan_d = scan_q; item_d = item_q;
    rerr_d = rerr_q; ovalid_d = ovalid_q; odata_d = odata_q;
    flip_start = 1'b0; we = 1'b0;
    if (ovalid_q && m_axis_tready) begin
      ovalid_d = 1'b0;
    end
    unique case (state_q)
      SIdle: begin
        if (in_acc) begin
          if (s_axis_tuser == CmdClear) begin
            fill_d = '0;
            odata_d = 16'd0;
            ovalid_d = 1'b1;
          end else begin
            item_d = entry_t'(s_axis_tdata[EntryBits-1:0]);
            rerr_d = ({16'd0, s_axis_tdata[SourceBits-1:0]} >= {{SourceBits{1'b0}}, vcount_q});
            state_d = SFlip;
          end
        end
      end
      SFlip: begin
        flip_start = 1'b1;
        state_d = SWait;
      end
      SWait: begin
        if (flip_done) begin
          item_d.v = flip_res;
          scan_d = '0;
          state_d = SScan;
        end
      end
      SScan: begin
        // Read address presented; data arrives next cycle.
        if (scan_q >= fill_q) begin
          state_d = SDone;
        end else begin
          state_d = SCheck;
        end
      end
      SCheck: begin
        if (hit) begin
          odata_d = 16'd0;
          odata_d[7:0] = scan_idx;
          odata_d[10] = rerr_q;
          ovalid_d = 1'b1;
          state_d = SIdle;
        end else begin
          scan_d = scan_q + CountBits'(1);
          state_d = SScan;
        end
      end
      SDone: begin
        odata_d = 16'd0;
        odata_d[10] = rerr_q;
        if (fill_q == CountBits'(TableDepth)) begin
          odata_d[9] = 1'b1;
        end else begin
          we = 1'b1;
          odata_d[8] = 1'b1;
          odata_d[7:0] = fill_idx;
          fill_d = fill_q + CountBits'(1);
        end
        ovalid_d = 1'b1;
        state_d = SIdle;
      end
      default: state_d = SIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= SIdle;
      fill_q   <= '0;
      ovalid_q <= 1'b0;
      by_src_q <= 1'b0;
      vcount_q <= '0;
    end else begin
      state_q  <= state_d;
      fill_q   <= fill_d;
      ovalid_q <= ovalid_d;
      if (cfg_we_i && cfg_index_i == CfgMatchBySource) begin
        by_src_q <= cfg_data_i[0];
      end
      if (cfg_we_i && cfg_index_i == CfgVertexCount) begin
        vcount_q <= cfg_data_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    scan_q  <= scan_d;
    item_q  <= item_d;
    rerr_q  <= rerr_d;
    odata_q <= odata_d;
  end

  assign m_axis_tvalid = ovalid_q;
  assign m_axis_tdata  = odata_q;

  a_fill_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fill_q <= CountBits'(TableDepth)) else $error("fill count beyond table depth");
  a_no_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q != SIdle) |-> !s_axis_tready) else $error("ready while busy");
  a_write_only_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    we |-> (fill_q < CountBits'(TableDepth))) else $error("append into full table");
  a_result_held: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (ovalid_q && !m_axis_tready) |=> (ovalid_q && $stable(odata_q)))
    else $error("result lost under stall");

endmodule
